>>> hdl/lfrc_pkg.sv
// Shared constants, item types and divider types for the LED fade ramp controller.
package lfrc_pkg;

    // Field widths
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned DLY_W  = 16;
    localparam int unsigned FADE_W = 16;
    localparam int unsigned LVL_W  = 12;

    // Full-scale level in PWM units
    localparam logic [LVL_W-1:0] FULL_SCALE = 12'd4095;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FADE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLAN = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // Config register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = FADE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PCT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PCT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MS = 2'd2;

    // Config reset values
    localparam logic [PCT_W-1:0]  MIN_PCT_RST = 7'd0;
    localparam logic [PCT_W-1:0]  MAX_PCT_RST = 7'd100;
    localparam logic [FADE_W-1:0] FADE_MS_RST = 16'd1000;

    // percent -> level: floor(p * FULL_SCALE / 100) via reciprocal multiply.
    // Error stays below 0.003 over all 7-bit percents, so the floor is exact.
    localparam int unsigned PCT_DIV    = 100;
    localparam int unsigned PCT_SHIFT  = 27;
    localparam int unsigned PCT_RECIP  = ((1 << PCT_SHIFT) + PCT_DIV - 1) / PCT_DIV;
    localparam int unsigned PCT_RCP_W  = 21;
    localparam int unsigned PCT_PROD_W = PCT_W + LVL_W + PCT_RCP_W;

    // Step divider: quotient < 2^LVL_W, divisor is 2*fade_ms
    localparam int unsigned QUOT_W     = LVL_W;
    localparam int unsigned DEN_W      = FADE_W + 1;
    localparam int unsigned NUM_W      = QUOT_W + DEN_W + 1;
    localparam int unsigned DIGIT_BITS = 3;
    localparam int unsigned DIV_STEPS  = QUOT_W / DIGIT_BITS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PCT_W-1:0] percent;
        logic [DLY_W-1:0] delay_ms;
    } t_in_item;

    typedef struct packed {
        logic [LVL_W-1:0] drive_value;
        logic             drive_update;
        logic [LVL_W-1:0] brightness;
        logic             fade_planned;
        logic             fade_running;
        logic             going_up;
        logic             plan_pending;
        logic             at_min;
        logic             at_max;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hdl/lfrc_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface lfrc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/lfrc_div.sv
// Digit-serial restoring divider for the ramp step, three quotient bits per cycle.
module lfrc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfrc_pkg::t_div_req i_req,
    output lfrc_pkg::t_div_rsp o_rsp
);

    logic                              r_busy;
    logic [lfrc_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [lfrc_pkg::DEN_W:0]          r_rem;
    logic [lfrc_pkg::QUOT_W-1:0]       r_low;
    logic [lfrc_pkg::DEN_W-1:0]        r_den;

    logic [lfrc_pkg::DEN_W:0]          n_rem;
    logic [lfrc_pkg::QUOT_W-1:0]       n_low;
    logic [lfrc_pkg::DEN_W:0]          trial;
    logic                              take;
    logic                              last_digit;

    // One digit: shift in numerator bits, compare-subtract, shift quotient bits in
    always_comb begin
        n_rem = r_rem;
        n_low = r_low;
        trial = '0;
        take  = 1'b0;
        for (int i = 0; i < lfrc_pkg::DIGIT_BITS; i++) begin
            trial = {n_rem[lfrc_pkg::DEN_W-1:0], n_low[lfrc_pkg::QUOT_W-1]};
            take  = trial >= {1'b0, r_den};
            n_rem = take ? (trial - {1'b0, r_den}) : trial;
            n_low = {n_low[lfrc_pkg::QUOT_W-2:0], take};
        end
    end

    assign last_digit = r_busy && (r_cnt == lfrc_pkg::DIV_CNT_W'(lfrc_pkg::DIV_STEPS - 1));

    // Remainder starts with the numerator bits above the quotient width;
    // the low shift register holds numerator bits out and quotient bits in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= i_req.num[lfrc_pkg::NUM_W-1:lfrc_pkg::QUOT_W];
            r_low  <= i_req.num[lfrc_pkg::QUOT_W-1:0];
            r_den  <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
            r_cnt <= r_cnt + lfrc_pkg::DIV_CNT_W'(1);
            if (last_digit) begin
                r_busy <= 1'b0;
            end
        end
    end

    // done marks the edge at which the last digit lands; quot is valid the cycle after
    assign o_rsp.done = last_digit;
    assign o_rsp.quot = r_low;

    // Partial remainder stays below the divisor while dividing
    ap_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder out of range");

endmodule

>>> hdl/led_fade_ramp_controller_top.sv
// LED fade ramp controller: one-channel linear dimmer with millisecond tick and fade plan.
// Paths: fade, plan and no-op beats go straight to the result register; a tick passes the plan,
//   elapsed and compare states, the longest path being a ramp step through the serial divider.
// Throughput: one item at a time; the next beat is taken the cycle after the result is
//   registered, and the result register waits while the output holds a result not yet taken.
// Reset: synchronous active-low i_rst_n clears time, fade state and the output valid; config
//   returns to min 0 %, max 100 %, fade 1000 ms.
module led_fade_ramp_controller_top #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lfrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lfrc_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    lfrc_stream_if.sink                      i_cmd_ch,
    lfrc_stream_if.source                    o_res_ch
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLAN,
        S_ELAP,
        S_CMP,
        S_PREP,
        S_DIV,
        S_STEP,
        S_DONE
    } t_state;

    // floor(p * FULL_SCALE / 100), one bit wider than a level
    function automatic logic [lfrc_pkg::LVL_W:0] f_pct_level(input logic [lfrc_pkg::PCT_W-1:0] p);
        logic [lfrc_pkg::PCT_PROD_W-1:0] prod;
        prod = lfrc_pkg::PCT_PROD_W'(p) * lfrc_pkg::PCT_PROD_W'(lfrc_pkg::FULL_SCALE)
             * lfrc_pkg::PCT_PROD_W'(lfrc_pkg::PCT_RECIP);
        return prod[lfrc_pkg::PCT_SHIFT +: lfrc_pkg::LVL_W+1];
    endfunction

    // Clamp to max then min (min wins), convert, saturate at full scale
    function automatic logic [lfrc_pkg::LVL_W-1:0] f_target(
        input logic [lfrc_pkg::PCT_W-1:0] pct,
        input logic [lfrc_pkg::PCT_W-1:0] minp,
        input logic [lfrc_pkg::PCT_W-1:0] maxp
    );
        logic [lfrc_pkg::PCT_W-1:0] p;
        logic [lfrc_pkg::LVL_W:0]   t;
        p = (pct > maxp) ? maxp : pct;
        p = (p < minp) ? minp : p;
        t = f_pct_level(p);
        return (t > {1'b0, lfrc_pkg::FULL_SCALE}) ? lfrc_pkg::FULL_SCALE : t[lfrc_pkg::LVL_W-1:0];
    endfunction

    // Inverted PWM drive; full scale and zero pass unchanged
    function automatic logic [lfrc_pkg::LVL_W-1:0] f_drive(input logic [lfrc_pkg::LVL_W-1:0] lv);
        logic [lfrc_pkg::LVL_W-1:0] d;
        if (lv == lfrc_pkg::FULL_SCALE) begin
            d = lfrc_pkg::FULL_SCALE;
        end else if (lv == '0) begin
            d = '0;
        end else begin
            d = lfrc_pkg::FULL_SCALE - lv;
        end
        return d;
    endfunction

    // Config registers
    logic [lfrc_pkg::PCT_W-1:0]  r_min_pct;
    logic [lfrc_pkg::PCT_W-1:0]  r_max_pct;
    logic [lfrc_pkg::FADE_W-1:0] r_fade_ms;

    // Fade state
    t_state                      r_state;
    logic [TIME_BITS-1:0]        r_now;
    logic [TIME_BITS-1:0]        r_start;
    logic [TIME_BITS-1:0]        r_prev;
    logic [TIME_BITS-1:0]        r_plan_start;
    logic [TIME_BITS-1:0]        r_elapsed;
    logic [lfrc_pkg::LVL_W-1:0]  r_target;
    logic [lfrc_pkg::LVL_W-1:0]  r_level;
    logic [lfrc_pkg::LVL_W-1:0]  r_last_drive;
    logic [lfrc_pkg::PCT_W-1:0]  r_plan_pct;
    logic [lfrc_pkg::FADE_W-1:0] r_delta;
    logic                        r_dir_up;
    logic                        r_armed;
    logic                        r_running;
    logic                        r_plan_valid;
    logic                        r_upd;
    lfrc_pkg::t_out_item         r_out;
    logic                        r_out_valid;

    logic                        in_fire;
    logic                        out_load;
    logic [TIME_BITS-1:0]        now_inc;
    logic [TIME_BITS-1:0]        plan_diff;
    logic                        plan_due;
    logic [TIME_BITS-1:0]        elapsed;
    logic [TIME_BITS-1:0]        item_when;
    logic [lfrc_pkg::LVL_W-1:0]  item_target;
    logic [lfrc_pkg::LVL_W-1:0]  plan_target;
    logic                        e_le_prev;
    logic                        e_ge_fade;
    logic [lfrc_pkg::LVL_W:0]    up_sum;
    logic [lfrc_pkg::LVL_W:0]    dn_sum;
    logic                        step_snap;
    logic [lfrc_pkg::LVL_W-1:0]  step_level;
    lfrc_pkg::t_div_req          div_req;
    lfrc_pkg::t_div_rsp          div_rsp;

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pct <= lfrc_pkg::MIN_PCT_RST;
            r_max_pct <= lfrc_pkg::MAX_PCT_RST;
            r_fade_ms <= lfrc_pkg::FADE_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfrc_pkg::CFG_MIN_PCT: r_min_pct <= i_cfg_data[lfrc_pkg::PCT_W-1:0];
                lfrc_pkg::CFG_MAX_PCT: r_max_pct <= i_cfg_data[lfrc_pkg::PCT_W-1:0];
                lfrc_pkg::CFG_FADE_MS: r_fade_ms <= i_cfg_data[lfrc_pkg::FADE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake
    assign i_cmd_ch.ready   = (r_state == S_IDLE);
    assign in_fire          = i_cmd_ch.valid && i_cmd_ch.ready;
    assign out_load         = (r_state == S_DONE) && (!r_out_valid || o_res_ch.ready);
    assign o_res_ch.valid   = r_out_valid;
    assign o_res_ch.payload = r_out;

    // Wrap-safe time arithmetic
    assign now_inc   = r_now + TIME_BITS'(1);
    assign plan_diff = r_plan_start - r_now;
    assign plan_due  = (plan_diff == '0) || plan_diff[TIME_BITS-1];
    assign elapsed   = r_now - r_start;
    assign item_when = r_now + TIME_BITS'(i_cmd_ch.payload.delay_ms);
    assign e_le_prev = r_elapsed <= r_prev;
    assign e_ge_fade = r_elapsed >= TIME_BITS'(r_fade_ms);

    // Fade targets
    assign item_target = f_target(i_cmd_ch.payload.percent, r_min_pct, r_max_pct);
    assign plan_target = f_target(r_plan_pct, r_min_pct, r_max_pct);

    // Step toward target; snap when reached or passed
    assign up_sum     = {1'b0, r_level} + {1'b0, div_rsp.quot};
    assign dn_sum     = {1'b0, r_target} + {1'b0, div_rsp.quot};
    assign step_snap  = r_dir_up ? (up_sum >= {1'b0, r_target}) : (dn_sum >= {1'b0, r_level});
    assign step_level = r_dir_up ? up_sum[lfrc_pkg::LVL_W-1:0] : (r_level - div_rsp.quot);

    // step = (2*FS*delta + fade) / (2*fade), rounds half up
    assign div_req.start = (r_state == S_PREP);
    assign div_req.num   = lfrc_pkg::NUM_W'({r_delta, {(lfrc_pkg::LVL_W+1){1'b0}}})
                         - lfrc_pkg::NUM_W'({r_delta, 1'b0})
                         + lfrc_pkg::NUM_W'(r_fade_ms);
    assign div_req.den   = {r_fade_ms, 1'b0};

    lfrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer, fade state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_start      <= '0;
            r_prev       <= '0;
            r_plan_start <= '0;
            r_target     <= '0;
            r_level      <= '0;
            r_last_drive <= '0;
            r_plan_pct   <= '0;
            r_dir_up     <= 1'b0;
            r_armed      <= 1'b0;
            r_running    <= 1'b0;
            r_plan_valid <= 1'b0;
            r_upd        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_upd <= 1'b0;
                        unique case (i_cmd_ch.payload.cmd)
                            lfrc_pkg::CMD_TICK: begin
                                r_now   <= now_inc;
                                r_state <= S_PLAN;
                            end
                            lfrc_pkg::CMD_FADE: begin
                                r_target <= item_target;
                                r_dir_up <= item_target > r_level;
                                r_start  <= item_when;
                                r_armed  <= 1'b1;
                                r_prev   <= '0;
                                r_state  <= S_DONE;
                            end
                            lfrc_pkg::CMD_PLAN: begin
                                r_plan_pct   <= i_cmd_ch.payload.percent;
                                r_plan_start <= item_when;
                                r_plan_valid <= 1'b1;
                                r_state      <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end

                // Pending plan fires once its start time is reached
                S_PLAN: begin
                    if (r_plan_valid && plan_due) begin
                        r_target     <= plan_target;
                        r_dir_up     <= plan_target > r_level;
                        r_start      <= r_plan_start;
                        r_armed      <= 1'b1;
                        r_prev       <= '0;
                        r_plan_valid <= 1'b0;
                    end
                    r_state <= S_ELAP;
                end

                // Nothing moves before the start time
                S_ELAP: begin
                    if (!r_armed || elapsed[TIME_BITS-1]) begin
                        r_state <= S_DONE;
                    end else begin
                        r_running <= 1'b1;
                        r_elapsed <= elapsed;
                        r_state   <= S_CMP;
                    end
                end

                // No new time: no change; full time: snap
                S_CMP: begin
                    if (e_le_prev) begin
                        r_state <= S_DONE;
                    end else if (e_ge_fade) begin
                        r_level      <= r_target;
                        r_armed      <= 1'b0;
                        r_running    <= 1'b0;
                        r_start      <= '0;
                        r_prev       <= r_elapsed;
                        r_last_drive <= f_drive(r_target);
                        r_upd        <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        // elapsed < fade_ms here, so the delta fits the fade width
                        r_delta <= r_elapsed[lfrc_pkg::FADE_W-1:0] - r_prev[lfrc_pkg::FADE_W-1:0];
                        r_state <= S_PREP;
                    end
                end

                S_PREP: r_state <= S_DIV;

                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_STEP;
                    end
                end

                S_STEP: begin
                    if (step_snap) begin
                        r_level      <= r_target;
                        r_armed      <= 1'b0;
                        r_running    <= 1'b0;
                        r_start      <= '0;
                        r_last_drive <= f_drive(r_target);
                    end else begin
                        r_level      <= step_level;
                        r_last_drive <= f_drive(step_level);
                    end
                    r_prev  <= r_elapsed;
                    r_upd   <= 1'b1;
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (out_load) begin
                        r_out.drive_value  <= r_last_drive;
                        r_out.drive_update <= r_upd;
                        r_out.brightness   <= r_level;
                        r_out.fade_planned <= r_armed;
                        r_out.fade_running <= r_running;
                        r_out.going_up     <= r_dir_up;
                        r_out.plan_pending <= r_plan_valid;
                        r_out.at_min       <= {1'b0, r_level} == f_pct_level(r_min_pct);
                        r_out.at_max       <= {1'b0, r_level} == f_pct_level(r_max_pct);
                        r_state            <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A running fade is always an armed one
    ap_run_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_armed)
        else $error("fade running without being armed");

    // Level never leaves the PWM range
    ap_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= lfrc_pkg::FULL_SCALE)
        else $error("brightness above full scale");

    // An update that ends the fade leaves the level on target
    ap_snap_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_upd && !r_armed) |-> (r_level == r_target))
        else $error("fade ended off target");

    // Drive register tracks the level it was written from
    ap_drive_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_drive == f_drive(r_level))
        else $error("drive value out of step with brightness");

endmodule
